// File: rtl/core/esort_pkg.sv
// ----------------------------------------------------------------------------
// esort_pkg
// Types and constants shared by the exchange sort controller, datapath and top unit.
// ----------------------------------------------------------------------------
package esort_pkg;

  localparam int MAX_ITEMS_DEFAULT = 64;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } esort_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               overflow;
  } esort_result_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_START,
    ST_I_LOAD,
    ST_J_RUN,
    ST_I_WB,
    ST_EMIT_START,
    ST_EMIT_SHOW
  } esort_state_t;

  typedef enum logic {
    WSEL_ITEM,
    WSEL_CUR
  } esort_wsel_t;

  typedef struct packed {
    logic        wr_en;
    esort_wsel_t wr_sel;
    logic        rd_en;
    logic        cur_load;
  } esort_cmd_t;

endpackage

// File: rtl/core/esort_dp.sv
// ----------------------------------------------------------------------------
// esort_dp
// Element store, running register for the position under sort, and the
// signed comparator that decides each exchange.
// ----------------------------------------------------------------------------
module esort_dp
  import esort_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT,
  parameter int AW        = $clog2(MAX_ITEMS)
) (
  input  logic               clk,
  input  esort_cmd_t         cmd,
  input  logic [AW-1:0]      wr_addr,
  input  logic [AW-1:0]      rd_addr,
  input  logic signed [31:0] value,
  output logic               swap,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [MAX_ITEMS];
  logic signed [31:0] cur;
  logic signed [31:0] wdata;

  assign wdata = (cmd.wr_sel == WSEL_ITEM) ? value : cur;

  // The earlier position is held in cur; a greater value there means the
  // pair is out of order and the two are exchanged.
  assign swap = cur > rdata;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
  end

  // The read register also serves as the output register while emitting,
  // so it only changes when a read is issued.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      cur <= rdata;
    end
  end

endmodule

// File: rtl/core/esort_ctrl.sv
// ----------------------------------------------------------------------------
// esort_ctrl
// Sequencer for loading a set, the exchange sort passes and emission of the
// sorted words. Owns the fill count, drop flag and loop indices.
// ----------------------------------------------------------------------------
module esort_ctrl
  import esort_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT,
  parameter int AW        = $clog2(MAX_ITEMS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  logic          item_last,
  output logic          result_valid,
  input  logic          result_ready,
  output logic          result_final,
  output logic          result_overflow,
  input  logic          swap,
  output esort_cmd_t    cmd,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_addr
);

  localparam int CW = AW + 1;

  esort_state_t  state;
  esort_state_t  state_next;
  logic [CW-1:0] fill;
  logic          dropped;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [AW-1:0] k;

  logic          item_acc;
  logic          result_acc;
  logic          store_ok;
  logic [CW-1:0] fill_after;
  logic [CW-1:0] last_idx;
  logic          j_at_end;
  logic          i_at_end;
  logic          k_at_end;

  assign item_acc   = item_valid && item_ready;
  assign result_acc = result_valid && result_ready;
  assign store_ok   = fill < CW'(MAX_ITEMS);
  assign fill_after = store_ok ? fill + CW'(1) : fill;
  assign last_idx   = fill - CW'(1);
  assign j_at_end   = {1'b0, j} == last_idx;
  assign i_at_end   = ({1'b0, i} + CW'(1)) == last_idx;
  assign k_at_end   = {1'b0, k} == last_idx;

  assign result_final    = k_at_end;
  assign result_overflow = dropped;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (item_acc && item_last) begin
          state_next = (fill_after >= CW'(2)) ? ST_SORT_START : ST_EMIT_START;
        end
      end
      ST_SORT_START: state_next = ST_I_LOAD;
      ST_I_LOAD:     state_next = ST_J_RUN;
      ST_J_RUN: begin
        if (j_at_end) begin
          state_next = ST_I_WB;
        end
      end
      ST_I_WB: begin
        state_next = i_at_end ? ST_EMIT_START : ST_I_LOAD;
      end
      ST_EMIT_START: state_next = ST_EMIT_SHOW;
      ST_EMIT_SHOW: begin
        if (result_acc && k_at_end) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd          = '{wr_en: 1'b0, wr_sel: WSEL_CUR, rd_en: 1'b0, cur_load: 1'b0};
    wr_addr      = i;
    rd_addr      = i;
    item_ready   = 1'b0;
    result_valid = 1'b0;
    case (state)
      ST_LOAD: begin
        item_ready = 1'b1;
        cmd.wr_en  = item_valid && store_ok;
        cmd.wr_sel = WSEL_ITEM;
        wr_addr    = fill[AW-1:0];
      end
      ST_SORT_START: begin
        cmd.rd_en = 1'b1;
        rd_addr   = i;
      end
      ST_I_LOAD: begin
        cmd.cur_load = 1'b1;
        cmd.rd_en    = 1'b1;
        rd_addr      = i + AW'(1);
      end
      ST_J_RUN: begin
        cmd.wr_en    = swap;
        cmd.cur_load = swap;
        wr_addr      = j;
        cmd.rd_en    = !j_at_end;
        rd_addr      = j + AW'(1);
      end
      ST_I_WB: begin
        cmd.wr_en = 1'b1;
        wr_addr   = i;
        cmd.rd_en = !i_at_end;
        rd_addr   = i + AW'(1);
      end
      ST_EMIT_START: begin
        cmd.rd_en = 1'b1;
        rd_addr   = '0;
      end
      ST_EMIT_SHOW: begin
        result_valid = 1'b1;
        cmd.rd_en    = result_ready && !k_at_end;
        rd_addr      = k + AW'(1);
      end
      default: begin
        cmd.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      fill    <= '0;
      dropped <= 1'b0;
      i       <= '0;
      j       <= '0;
      k       <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          i <= '0;
          if (item_acc) begin
            fill <= fill_after;
            if (!store_ok) begin
              dropped <= 1'b1;
            end
          end
        end
        ST_I_LOAD: j <= i + AW'(1);
        ST_J_RUN: begin
          if (!j_at_end) begin
            j <= j + AW'(1);
          end
        end
        ST_I_WB: begin
          if (!i_at_end) begin
            i <= i + AW'(1);
          end
        end
        ST_EMIT_START: k <= '0;
        ST_EMIT_SHOW: begin
          if (result_acc) begin
            if (k_at_end) begin
              fill    <= '0;
              dropped <= 1'b0;
            end else begin
              k <= k + AW'(1);
            end
          end
        end
        default: begin
          k <= k;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.rd_en) |-> (wr_addr != rd_addr))
    else $error("store read and write hit the same entry");

  a_sides_apart: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("loading and emitting at once");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  a_j_after_i: assert property (@(posedge clk) disable iff (rst)
    (state == ST_J_RUN) |-> (j > i))
    else $error("inner index not beyond outer index");

  a_set_closes: assert property (@(posedge clk) disable iff (rst)
    (result_acc && k_at_end) |=> (fill == '0 && !dropped && state == ST_LOAD))
    else $error("set not cleared after its final word");
`endif

endmodule

// File: rtl/core/exchange_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// exchange_sort_engine_unit
// Loading: item_ready stays high, so a word is taken whenever one is offered.
// Sort of N >= 2 stored words runs a compare and write-back loop; a one-word set skips it.
// Emission: a first read of the store, then one word per cycle while the result side is ready.
// Sets do not overlap: no word is taken while a set is sorted or emitted.
// Synchronous reset empties the open set; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module exchange_sort_engine_unit
  import esort_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  esort_item_t   item,
  output logic          result_valid,
  input  logic          result_ready,
  output esort_result_t result
);

  localparam int AW = $clog2(MAX_ITEMS);

  esort_cmd_t         cmd;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic               swap;
  logic signed [31:0] rdata;
  logic               result_final;
  logic               result_overflow;

  esort_ctrl #(
    .MAX_ITEMS(MAX_ITEMS),
    .AW       (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item_last      (item.last),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_final   (result_final),
    .result_overflow(result_overflow),
    .swap           (swap),
    .cmd            (cmd),
    .wr_addr        (wr_addr),
    .rd_addr        (rd_addr)
  );

  esort_dp #(
    .MAX_ITEMS(MAX_ITEMS),
    .AW       (AW)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .wr_addr(wr_addr),
    .rd_addr(rd_addr),
    .value  (item.value),
    .swap   (swap),
    .rdata  (rdata)
  );

  always_comb begin
    result.sorted_value = rdata;
    result.final_res    = result_final;
    result.overflow     = result_overflow;
  end

endmodule
